FILE: rtl/snmc_pkg.sv
`default_nettype none

package snmc_pkg;

    typedef logic [31:0] t_word;
    typedef logic [63:0] t_prod;
    typedef logic [26:0] t_resid;
    typedef logic [14:0] t_small;

    localparam int unsigned EXP_BITS = 15;

    localparam t_resid MODULUS     = 27'd99999997;
    localparam t_small BASE_OFFSET = 15'd1011;
    localparam t_small EXP_OFFSET  = 15'd3;
    localparam logic [7:0] SERIAL_LENGTH = 8'd16;

    // floor(v * RECIP10 / 2^35) == v / 10 for any 32-bit v
    localparam t_word RECIP10    = 32'hCCCCCCCD;
    localparam int unsigned RECIP10_SHIFT = 35;

    // shift positions of the modulus used by the restoring reduction
    localparam int unsigned RED_STEPS = 6;

endpackage

`default_nettype wire

FILE: rtl/snmc_if.sv
`default_nettype none

interface snmc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] original_digits;
    logic [31:0] given_check_digits;
    logic [7:0]  serial_length;

    modport source (
        output valid, original_digits, given_check_digits, serial_length,
        input  ready
    );
    modport sink (
        input  valid, original_digits, given_check_digits, serial_length,
        output ready
    );
endinterface

interface snmc_out_if;
    logic        valid;
    logic        ready;
    logic [26:0] check_value;
    logic [31:0] check_bcd;
    logic [63:0] serial_bcd;
    logic        valid_res;
    logic        digit_error;

    modport source (
        output valid, check_value, check_bcd, serial_bcd, valid_res, digit_error,
        input  ready
    );
    modport sink (
        input  valid, check_value, check_bcd, serial_bcd, valid_res, digit_error,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/snmc_mul.sv
`default_nettype none

// shared 32x32 multiplier, full product registered
module snmc_mul (
    input  wire                 i_clk,
    input  snmc_pkg::t_word     i_a,
    input  snmc_pkg::t_word     i_b,
    output snmc_pkg::t_prod     o_p
);

    snmc_pkg::t_prod r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: rtl/serial_number_modexp_check_unit.sv
// serial number check unit
//
// input channel i_in: eight payload bcd digits, eight claimed check digits and
// the serial length; one transfer starts one check. output channel o_out: the
// check number in binary and in bcd, the interleaved sixteen-digit serial, the
// valid flag and the digit error flag; exactly one transfer per input.
//
// the exponent is walked over 15 bits, msb first; each bit costs a square on
// the shared multiplier, a second multiply by the base when the bit is set,
// and a six-step compare-subtract reduction modulo 99999997. the bcd
// conversion then issues one multiply by the reciprocal of ten per digit on
// the same multiplier. one check runs at a time: a new input is taken only
// once the last check has loaded its result into the output register.
//
// i_in.ready is high whenever no check is running, also while a finished
// result still waits in the output register. if the receiver stalls, the next
// check runs to its end and then holds until the output register is free.
// reset (i_rst_n low, synchronous) returns the sequencer to idle and drops
// o_out.valid; nothing else needs clearing.

`default_nettype none

module serial_number_modexp_check_unit (
    input  wire               i_clk,
    input  wire               i_rst_n,
    snmc_in_if.sink           i_in,
    snmc_out_if.source        o_out
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;  // issue r*r
    localparam logic [2:0] ST_SQR  = 3'd2;  // square ready, *base issued, used when the bit is set
    localparam logic [2:0] ST_BMR  = 3'd3;  // base product ready
    localparam logic [2:0] ST_RED  = 3'd4;  // one compare-subtract per cycle
    localparam logic [2:0] ST_DIV  = 3'd5;  // issue v * recip10
    localparam logic [2:0] ST_DIVR = 3'd6;  // peel one decimal digit
    localparam logic [2:0] ST_FIN  = 3'd7;  // load output register

    localparam logic [3:0] BIT_TOP = 4'(snmc_pkg::EXP_BITS - 1);
    localparam logic [2:0] K_TOP   = 3'(snmc_pkg::RED_STEPS - 1);

    // control state
    logic [2:0] r_state, n_state;
    logic [3:0] r_bit,   n_bit;
    logic [2:0] r_k,     n_k;
    logic [2:0] r_dcnt,  n_dcnt;
    logic       r_out_valid, n_out_valid;

    // datapath registers
    logic [31:0]            r_digits,  n_digits;
    logic [31:0]            r_given,   n_given;
    logic [7:0]             r_len,     n_len;
    logic                   r_derr,    n_derr;
    snmc_pkg::t_small       r_base,    n_base;
    snmc_pkg::t_small       r_exp,     n_exp;
    snmc_pkg::t_resid       r_r,       n_r;
    snmc_pkg::t_word        r_x,       n_x;
    snmc_pkg::t_resid       r_v,       n_v;
    snmc_pkg::t_resid       r_check,   n_check;
    logic [31:0]            r_cbcd,    n_cbcd;

    // output register
    logic [26:0] r_o_check, n_o_check;
    logic [31:0] r_o_cbcd,  n_o_cbcd;
    logic [63:0] r_o_serial, n_o_serial;
    logic        r_o_valid_res, n_o_valid_res;
    logic        r_o_derr,  n_o_derr;

    // shared multiplier
    snmc_pkg::t_word mul_a, mul_b;
    snmc_pkg::t_prod mul_p;

    snmc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    logic            in_xfer, out_xfer, out_free;
    snmc_pkg::t_small base_in, exp_in;
    logic            derr_in;
    snmc_pkg::t_word red_sub, red_diff, red_next;
    logic [26:0]     quot;
    logic [26:0]     rem10;
    logic [63:0]     serial;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // base and exponent from the decimal payload digits
    always_comb begin
        base_in = snmc_pkg::BASE_OFFSET
                + 15'(i_in.original_digits[31:28]) * 15'd1000
                + 15'(i_in.original_digits[27:24]) * 15'd100
                + 15'(i_in.original_digits[23:20]) * 15'd10
                + 15'(i_in.original_digits[19:16]);
        exp_in  = snmc_pkg::EXP_OFFSET
                + 15'(i_in.original_digits[15:12]) * 15'd1000
                + 15'(i_in.original_digits[11:8])  * 15'd100
                + 15'(i_in.original_digits[7:4])   * 15'd10
                + 15'(i_in.original_digits[3:0]);
    end

    // any nibble above nine in either word
    always_comb begin
        derr_in = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i_in.original_digits[4*i +: 4] > 4'd9 ||
                i_in.given_check_digits[4*i +: 4] > 4'd9) begin
                derr_in = 1'b1;
            end
        end
    end

    // restoring reduction step: subtract modulus << k when it fits
    assign red_sub  = 32'(snmc_pkg::MODULUS) << r_k;
    assign red_diff = r_x - red_sub;
    assign red_next = (r_x >= red_sub) ? red_diff : r_x;

    // quotient by ten and remainder
    assign quot  = mul_p[snmc_pkg::RECIP10_SHIFT +: 27];
    assign rem10 = r_v - ((quot << 3) + (quot << 1));

    // interleave computed check digits with payload digits
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            serial[8*i +: 8] = {r_cbcd[4*i +: 4], r_digits[4*i +: 4]};
        end
    end

    // multiplier operand select
    always_comb begin
        unique case (r_state)
            ST_SQ: begin
                mul_a = 32'(r_r);
                mul_b = 32'(r_r);
            end
            ST_SQR: begin
                mul_a = mul_p[31:0];
                mul_b = 32'(r_base);
            end
            ST_DIV: begin
                mul_a = 32'(r_v);
                mul_b = snmc_pkg::RECIP10;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        n_k         = r_k;
        n_dcnt      = r_dcnt;
        n_out_valid = r_out_valid;
        n_digits    = r_digits;
        n_given     = r_given;
        n_len       = r_len;
        n_derr      = r_derr;
        n_base      = r_base;
        n_exp       = r_exp;
        n_r         = r_r;
        n_x         = r_x;
        n_v         = r_v;
        n_check     = r_check;
        n_cbcd      = r_cbcd;
        n_o_check     = r_o_check;
        n_o_cbcd      = r_o_cbcd;
        n_o_serial    = r_o_serial;
        n_o_valid_res = r_o_valid_res;
        n_o_derr      = r_o_derr;

        if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_digits = i_in.original_digits;
                    n_given  = i_in.given_check_digits;
                    n_len    = i_in.serial_length;
                    n_derr   = derr_in;
                    n_base   = base_in;
                    n_exp    = exp_in;
                    n_r      = 27'd1;
                    n_bit    = BIT_TOP;
                    n_state  = ST_SQ;
                end
            end
            ST_SQ: begin
                n_state = ST_SQR;
            end
            ST_SQR: begin
                if (r_exp[r_bit]) begin
                    n_state = ST_BMR;
                end else begin
                    n_x     = mul_p[31:0];
                    n_k     = K_TOP;
                    n_state = ST_RED;
                end
            end
            ST_BMR: begin
                n_x     = mul_p[31:0];
                n_k     = K_TOP;
                n_state = ST_RED;
            end
            ST_RED: begin
                n_x = red_next;
                n_k = r_k - 3'd1;
                if (r_k == 3'd0) begin
                    n_r = red_next[26:0];
                    if (r_bit == 4'd0) begin
                        n_v     = red_next[26:0];
                        n_check = red_next[26:0];
                        n_dcnt  = 3'd0;
                        n_state = ST_DIV;
                    end else begin
                        n_bit   = r_bit - 4'd1;
                        n_state = ST_SQ;
                    end
                end
            end
            ST_DIV: begin
                n_state = ST_DIVR;
            end
            ST_DIVR: begin
                // least significant digit first, shifted in from the top
                n_cbcd = {rem10[3:0], r_cbcd[31:4]};
                n_v    = quot;
                n_dcnt = r_dcnt + 3'd1;
                n_state = (r_dcnt == 3'd7) ? ST_FIN : ST_DIV;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_o_check     = r_check;
                    n_o_cbcd      = r_cbcd;
                    n_o_serial    = serial;
                    n_o_valid_res = (r_len == snmc_pkg::SERIAL_LENGTH) && !r_derr
                                    && (r_cbcd == r_given);
                    n_o_derr      = r_derr;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bit       <= '0;
            r_k         <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_k         <= n_k;
            r_dcnt      <= n_dcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits      <= n_digits;
        r_given       <= n_given;
        r_len         <= n_len;
        r_derr        <= n_derr;
        r_base        <= n_base;
        r_exp         <= n_exp;
        r_r           <= n_r;
        r_x           <= n_x;
        r_v           <= n_v;
        r_check       <= n_check;
        r_cbcd        <= n_cbcd;
        r_o_check     <= n_o_check;
        r_o_cbcd      <= n_o_cbcd;
        r_o_serial    <= n_o_serial;
        r_o_valid_res <= n_o_valid_res;
        r_o_derr      <= n_o_derr;
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.check_value = r_o_check;
    assign o_out.check_bcd   = r_o_cbcd;
    assign o_out.serial_bcd  = r_o_serial;
    assign o_out.valid_res   = r_o_valid_res;
    assign o_out.digit_error = r_o_derr;

    // an accepted check always starts with a square
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_SQ))
        else $error("check did not start after input transfer");

    // the last reduction step leaves a residue below the modulus
    a_residue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RED && r_k == 3'd0) |=> (r_r < snmc_pkg::MODULUS))
        else $error("residue not reduced");

    // each peeled decimal digit is a legal bcd digit
    a_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVR) |-> (rem10 < 27'd10))
        else $error("bcd digit out of range");

    // a finished result is never dropped while the receiver stalls
    a_nodrop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_out_valid && !o_out.ready) |=> (r_state == ST_FIN))
        else $error("result overwrote a pending transfer");

    // the reduction counter stays within its six steps
    a_kcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RED) |-> (r_k <= K_TOP))
        else $error("reduction step counter out of range");

endmodule

`default_nettype wire
